// File: sv/dmxsip_pkg.sv
package dmxsip_pkg;

	// Result kinds reported with every result transaction.
	localparam logic [2:0] KIND_STORED  = 3'd0;
	localparam logic [2:0] KIND_SIP_OK  = 3'd1;
	localparam logic [2:0] KIND_SIP_BAD = 3'd2;
	localparam logic [2:0] KIND_READ    = 3'd3;
	localparam logic [2:0] KIND_UNAVAIL = 3'd4;
	localparam logic [2:0] KIND_RANGE   = 3'd5;

	// Operation codes carried by an input transaction.
	localparam logic OP_RECEIVE = 1'b0;
	localparam logic OP_READ    = 1'b1;

	// A system information packet is exactly this many bytes long.
	localparam int SIP_LEN = 25;
	// Bit of SIP byte 2 that requests holding of the next regular packet.
	localparam int HOLD_BIT = 0;
	localparam logic [7:0] START_CODE_RESET = 8'd207;
	localparam logic [7:0] NULL_START_CODE  = 8'd0;

	typedef struct packed {
		logic       operation;
		logic [7:0] data_byte;
		logic       last_byte;
		logic [9:0] channel;
		logic       release_req;
	} in_t;

	typedef struct packed {
		logic [2:0]  result_kind;
		logic [7:0]  read_data;
		logic [7:0]  sip_sequence;
		logic [7:0]  sip_universe;
		logic [7:0]  sip_level;
		logic [7:0]  sip_version;
		logic [15:0] sip_packet_length;
		logic [15:0] sip_packet_count;
		logic        previous_checksum_ok;
		logic        previous_present;
	} out_t;

	// Control from the packet logic to the byte store.
	typedef struct packed {
		logic wr_en;
		logic rd_en;
		logic bank;
	} store_ctl_t;

endpackage

// File: sv/dmxsip_store.sv
module dmxsip_store #(
	parameter int MAX_PACKET_BYTES = 513,
	parameter int LW = 10
) (
	input  logic                    clk,
	input  dmxsip_pkg::store_ctl_t  ctl,
	input  logic [LW-1:0]           idx,
	input  logic [7:0]              wdata,
	output logic [7:0]              rdata_q
);

	localparam int DEPTH = 2 * MAX_PACKET_BYTES;
	localparam int AW = $clog2(DEPTH);

	logic [7:0]  mem [DEPTH];
	logic [AW:0] addr_wide;
	logic [AW-1:0] addr;

	// Bank 1 starts right after bank 0; the index stays below the bank size
	// whenever the access matters.
	assign addr_wide = (AW+1)'(idx) + (ctl.bank ? (AW+1)'(MAX_PACKET_BYTES) : '0);
	assign addr = addr_wide[AW-1:0];

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[addr] <= wdata;
		end
		if (ctl.rd_en) begin
			rdata_q <= mem[addr];
		end
	end

endmodule

// File: sv/dmx_sip_packet_holder_core.sv
// DMX packet receiver with system information packet (SIP) checking.
// Input channel (item_valid/item_ready, payload item): a receive transaction
// carries one packet byte, with last_byte set on the final byte of the
// packet; a read transaction fetches one channel of the stored packet.
// Output channel (result_valid/result_ready, payload result): one result
// per final byte and per read; other bytes give none. Every result carries
// the fields of the last accepted SIP.
// Configuration channel (cfg_valid/cfg_ready, cfg_data): SIP start code,
// always ready; write it only while the block is idle.
// A result passes the synchronous read of the two-bank byte store and then
// the output register between acceptance and result_valid.
// Throughput is one transaction per cycle while item_ready is high; the
// single store port serves the byte write or channel read of each one.
// When the receiver stalls, one result waits in the output register and one
// in the read stage; item_ready drops only when both are occupied.
// Reset clears SIP fields and control state save cap_q and stored_start_q.
// The byte store needs no clearing; reads are bounded by the stored length.
module dmx_sip_packet_holder_core #(
	parameter int MAX_PACKET_BYTES = 513
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  dmxsip_pkg::in_t     item,
	output logic                result_valid,
	input  logic                result_ready,
	output dmxsip_pkg::out_t    result,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [7:0]          cfg_data
);

	localparam int LW  = $clog2(MAX_PACKET_BYTES + 2);
	localparam int SLW = $clog2(MAX_PACKET_BYTES + 1);
	localparam int CW  = (LW > 10) ? LW : 10;
	localparam int SL  = dmxsip_pkg::SIP_LEN;

	localparam logic [1:0] MODE_IMMEDIATE = 2'd0;
	localparam logic [1:0] MODE_HOLD_NEXT = 2'd1;
	localparam logic [1:0] MODE_SIP_CHECK = 2'd2;

	// Control state
	logic [7:0]     start_code_q;
	logic           bank_q;
	logic [SLW-1:0] stored_len_q;
	logic [15:0]    stored_sum_q;
	logic [7:0]     stored_start_q;
	logic [LW-1:0]  inc_len_q;
	logic [15:0]    sum_wide_q;
	logic [7:0]     sum_narrow_q;
	logic [7:0]     cap_q [SL];
	logic [1:0]     mode_q;
	logic           held_q;

	// Fields of the last accepted SIP
	logic [7:0]  seq_q, uni_q, lvl_q, ver_q;
	logic [15:0] plen_q, pcnt_q;
	logic        ok_q, present_q;

	// Pipeline
	logic                    s1_valid_s1;
	logic [2:0]              kind_s1;
	logic [7:0]              rdata_q;
	dmxsip_pkg::out_t        out_q;
	logic                    out_valid_q;

	logic acc, is_rx, is_rd, finish, produces, out_free, s1_move;

	// Receive path, next values including the current byte
	logic           in_store;
	logic [LW-1:0]  len_n;
	logic [15:0]    wide_n;
	logic [7:0]     narrow_n;
	logic [7:0]     cap_n [SL];

	// Packet finish decisions
	logic           is_sip, sip_good, hold_req, prev_present, prev_ok;
	logic           keep, clr_len, sip_load;
	logic [1:0]     mode_n;
	logic           held_n;
	logic [2:0]     fin_kind;
	logic [SLW-1:0] commit_len;

	// Read path
	logic [CW-1:0]  ch_ext;
	logic [2:0]     rd_kind;

	dmxsip_pkg::store_ctl_t store_ctl;
	logic [LW-1:0]          store_idx;

	assign cfg_ready = 1'b1;
	assign out_free = !out_valid_q || result_ready;
	assign s1_move = s1_valid_s1 && out_free;
	assign item_ready = !s1_valid_s1 || out_free;
	assign acc = item_valid && item_ready;
	assign is_rx = acc && (item.operation == dmxsip_pkg::OP_RECEIVE);
	assign is_rd = acc && (item.operation == dmxsip_pkg::OP_READ);
	assign finish = is_rx && item.last_byte;
	assign produces = is_rd || finish;

	assign in_store = inc_len_q < LW'(MAX_PACKET_BYTES);
	assign len_n = (inc_len_q <= LW'(MAX_PACKET_BYTES)) ? inc_len_q + LW'(1) : inc_len_q;
	assign wide_n = in_store ? sum_wide_q + 16'(item.data_byte) : sum_wide_q;
	assign narrow_n = (inc_len_q < LW'(SL - 1)) ? sum_narrow_q + item.data_byte
		: sum_narrow_q;

	always_comb begin
		for (int i = 0; i < SL; i++) begin
			cap_n[i] = (inc_len_q == LW'(i)) ? item.data_byte : cap_q[i];
		end
	end

	assign is_sip = cap_n[0] == start_code_q;
	assign sip_good = (len_n == LW'(SL)) && (~narrow_n == cap_n[SL-1]);
	assign hold_req = cap_n[2][dmxsip_pkg::HOLD_BIT];
	assign prev_present = stored_len_q != '0;
	assign prev_ok = prev_present && ({cap_n[3], cap_n[4]} == ~stored_sum_q);
	assign commit_len = (len_n > LW'(MAX_PACKET_BYTES)) ? SLW'(MAX_PACKET_BYTES)
		: len_n[SLW-1:0];

	always_comb begin
		fin_kind = dmxsip_pkg::KIND_STORED;
		keep = 1'b1;
		clr_len = 1'b0;
		sip_load = 1'b0;
		mode_n = mode_q;
		held_n = held_q;
		if (is_sip) begin
			if (!sip_good) begin
				fin_kind = dmxsip_pkg::KIND_SIP_BAD;
				mode_n = MODE_IMMEDIATE;
				held_n = 1'b0;
			end else begin
				fin_kind = dmxsip_pkg::KIND_SIP_OK;
				sip_load = 1'b1;
				case (mode_q)
					MODE_HOLD_NEXT: begin
						if (!hold_req) begin
							mode_n = MODE_IMMEDIATE;
						end
					end
					MODE_SIP_CHECK: begin
						// The held packet survives only if the SIP vouches for it.
						clr_len = !prev_ok;
						held_n = 1'b0;
						keep = 1'b0;
						mode_n = hold_req ? MODE_HOLD_NEXT : MODE_IMMEDIATE;
					end
					default: begin
						if (hold_req) begin
							mode_n = MODE_HOLD_NEXT;
						end
					end
				endcase
			end
		end else if (cap_n[0] == dmxsip_pkg::NULL_START_CODE) begin
			case (mode_q)
				MODE_HOLD_NEXT: begin
					held_n = 1'b1;
					mode_n = MODE_SIP_CHECK;
				end
				MODE_SIP_CHECK: begin
					held_n = 1'b0;
					mode_n = MODE_IMMEDIATE;
				end
				default: begin
					mode_n = mode_q;
				end
			endcase
		end else if (mode_q == MODE_SIP_CHECK) begin
			held_n = 1'b0;
			mode_n = MODE_IMMEDIATE;
		end
	end

	assign ch_ext = CW'(item.channel);

	always_comb begin
		if (held_q || stored_len_q == '0 || stored_start_q == start_code_q) begin
			rd_kind = dmxsip_pkg::KIND_UNAVAIL;
		end else if (ch_ext >= CW'(stored_len_q)) begin
			rd_kind = dmxsip_pkg::KIND_RANGE;
		end else begin
			rd_kind = dmxsip_pkg::KIND_READ;
		end
	end

	// Writes go to the idle bank, reads to the bank holding the stored packet.
	assign store_ctl.wr_en = is_rx && in_store;
	assign store_ctl.rd_en = is_rd;
	assign store_ctl.bank = is_rx ? !bank_q : bank_q;
	assign store_idx = is_rx ? inc_len_q : ch_ext[LW-1:0];

	dmxsip_store #(
		.MAX_PACKET_BYTES(MAX_PACKET_BYTES),
		.LW(LW)
	) u_store (
		.clk(clk),
		.ctl(store_ctl),
		.idx(store_idx),
		.wdata(item.data_byte),
		.rdata_q(rdata_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_code_q <= dmxsip_pkg::START_CODE_RESET;
			bank_q <= 1'b0;
			stored_len_q <= '0;
			stored_sum_q <= '0;
			inc_len_q <= '0;
			sum_wide_q <= '0;
			sum_narrow_q <= '0;
			mode_q <= MODE_IMMEDIATE;
			held_q <= 1'b0;
			seq_q <= '0;
			uni_q <= '0;
			lvl_q <= '0;
			ver_q <= '0;
			plen_q <= '0;
			pcnt_q <= '0;
			ok_q <= 1'b0;
			present_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				start_code_q <= cfg_data;
			end
			if (is_rx) begin
				if (item.last_byte) begin
					inc_len_q <= '0;
					sum_wide_q <= '0;
					sum_narrow_q <= '0;
				end else begin
					inc_len_q <= len_n;
					sum_wide_q <= wide_n;
					sum_narrow_q <= narrow_n;
				end
			end
			if (finish) begin
				mode_q <= mode_n;
				held_q <= held_n;
				if (keep) begin
					bank_q <= !bank_q;
					stored_len_q <= commit_len;
					stored_sum_q <= wide_n;
				end else if (clr_len) begin
					stored_len_q <= '0;
				end
				if (sip_load) begin
					seq_q <= cap_n[5];
					uni_q <= cap_n[6];
					lvl_q <= cap_n[7];
					ver_q <= cap_n[8];
					plen_q <= {cap_n[9], cap_n[10]};
					pcnt_q <= {cap_n[11], cap_n[12]};
					ok_q <= prev_ok;
					present_q <= prev_present;
				end
			end
			if (is_rd && rd_kind == dmxsip_pkg::KIND_READ && item.release_req) begin
				stored_len_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (is_rx) begin
			cap_q <= cap_n;
		end
		if (finish && keep) begin
			stored_start_q <= cap_n[0];
		end
	end

	// Read stage: holds the transaction while the store registers its read data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (acc && produces) begin
			s1_valid_s1 <= 1'b1;
		end else if (s1_move) begin
			s1_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && produces) begin
			kind_s1 <= is_rd ? rd_kind : fin_kind;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_move) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Nothing is accepted while the read stage is stalled, so the SIP
	// registers still belong to the transaction held there.
	always_ff @(posedge clk) begin
		if (s1_move) begin
			out_q.result_kind <= kind_s1;
			out_q.read_data <= (kind_s1 == dmxsip_pkg::KIND_READ) ? rdata_q : 8'd0;
			out_q.sip_sequence <= seq_q;
			out_q.sip_universe <= uni_q;
			out_q.sip_level <= lvl_q;
			out_q.sip_version <= ver_q;
			out_q.sip_packet_length <= plen_q;
			out_q.sip_packet_count <= pcnt_q;
			out_q.previous_checksum_ok <= ok_q;
			out_q.previous_present <= present_q;
		end
	end

	assign result_valid = out_valid_q;
	assign result = out_q;

endmodule

// File: sv/dmxsip_checker.sv
module dmxsip_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             result_valid,
	input logic             result_ready,
	input dmxsip_pkg::out_t result
);

	a_reset_idle: assert property (@(posedge clk) !arst_n |-> !result_valid)
		else $error("result_valid high during reset");

	a_hold_stall: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("stalled result transaction changed");

	a_data_kind: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.result_kind != dmxsip_pkg::KIND_READ
		|-> result.read_data == 8'd0)
		else $error("read_data nonzero outside a read result");

	a_ok_present: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.previous_checksum_ok |-> result.previous_present)
		else $error("checksum match reported without a stored packet");

endmodule

bind dmx_sip_packet_holder_core dmxsip_checker u_dmxsip_checker (
	.clk(clk),
	.arst_n(arst_n),
	.result_valid(result_valid),
	.result_ready(result_ready),
	.result(result)
);

// File: tb/testbench.sv
module testbench;

	localparam int MAXB = 513;
	localparam int unsigned IDLE_LIMIT = 4000;

	typedef enum logic [1:0] {
		HOLD_OFF   = 2'd0,
		HOLD_NEXT  = 2'd1,
		HOLD_CHECK = 2'd2
	} hold_t;

	typedef enum int {
		FLAW_NONE  = 0,
		FLAW_SUM   = 1,
		FLAW_SHORT = 2,
		FLAW_LONG  = 3
	} sip_flaw_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_ready;
	dmxsip_pkg::in_t item = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	dmxsip_pkg::out_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [7:0] cfg_data = dmxsip_pkg::START_CODE_RESET;

	dmx_sip_packet_holder_core #(
		.MAX_PACKET_BYTES(MAXB)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	// Shadow copy of the receiver state.
	logic [7:0] shadow_bytes [0:2*MAXB-1];
	logic [7:0] shadow_code = dmxsip_pkg::START_CODE_RESET;
	logic shadow_bank = 1'b0;
	int unsigned shadow_len = 0;
	logic [15:0] shadow_sum = '0;
	int unsigned rx_len = 0;
	logic [15:0] rx_sum16 = '0;
	logic [7:0] rx_sum8 = '0;
	logic [7:0] rx_head [0:dmxsip_pkg::SIP_LEN-1];
	hold_t hold_state = HOLD_OFF;
	logic held = 1'b0;
	logic [63:0] sip_info = '0;
	logic sip_match = 1'b0;
	logic sip_had_prev = 1'b0;
	dmxsip_pkg::out_t results_due [$];

	dmxsip_pkg::in_t items_to_send [$];
	int unsigned send_gap = 0;
	int unsigned send_calm = 0;
	int unsigned stall_left = 0;
	int unsigned stall_calm = 0;
	int unsigned idle_cycles = 0;
	int unsigned n_bytes = 0;
	int unsigned n_reads = 0;
	int unsigned kinds_seen [0:7];
	int unsigned code_settings = 1;
	int fail_count = 0;

	logic [7:0] gen_code = dmxsip_pkg::START_CODE_RESET;
	logic [15:0] gen_last_sum = '0;
	int unsigned gen_last_len = 0;
	int unsigned gen_count = 0;

	function automatic dmxsip_pkg::out_t shape_result(input logic [2:0] kind,
			input logic [7:0] data);
		dmxsip_pkg::out_t r;
		r.result_kind = kind;
		r.read_data = data;
		{r.sip_sequence, r.sip_universe, r.sip_level, r.sip_version,
			r.sip_packet_length, r.sip_packet_count} = sip_info;
		r.previous_checksum_ok = sip_match;
		r.previous_present = sip_had_prev;
		return r;
	endfunction

	function automatic logic [2:0] close_packet();
		logic [7:0] start;
		logic hold_req;
		logic keep;
		logic [2:0] kind;
		start = rx_head[0];
		hold_req = rx_head[2][dmxsip_pkg::HOLD_BIT];
		keep = 1'b1;
		kind = dmxsip_pkg::KIND_STORED;
		if (start == shadow_code) begin
			if (rx_len != dmxsip_pkg::SIP_LEN ||
					~rx_sum8 != rx_head[dmxsip_pkg::SIP_LEN-1]) begin
				hold_state = HOLD_OFF;
				held = 1'b0;
				kind = dmxsip_pkg::KIND_SIP_BAD;
			end else begin
				kind = dmxsip_pkg::KIND_SIP_OK;
				sip_info = {rx_head[5], rx_head[6], rx_head[7], rx_head[8],
					rx_head[9], rx_head[10], rx_head[11], rx_head[12]};
				sip_had_prev = shadow_len > 0;
				sip_match = sip_had_prev && ({rx_head[3], rx_head[4]} == ~shadow_sum);
				case (hold_state)
					HOLD_NEXT: if (!hold_req) hold_state = HOLD_OFF;
					HOLD_CHECK: begin
						// The held packet survives only if the SIP vouches for it.
						if (!sip_match) shadow_len = 0;
						held = 1'b0;
						keep = 1'b0;
						hold_state = hold_req ? HOLD_NEXT : HOLD_OFF;
					end
					default: if (hold_req) hold_state = HOLD_NEXT;
				endcase
			end
		end else if (start == dmxsip_pkg::NULL_START_CODE) begin
			if (hold_state == HOLD_NEXT) begin
				held = 1'b1;
				hold_state = HOLD_CHECK;
			end else if (hold_state == HOLD_CHECK) begin
				held = 1'b0;
				hold_state = HOLD_OFF;
			end
		end else if (hold_state == HOLD_CHECK) begin
			held = 1'b0;
			hold_state = HOLD_OFF;
		end
		if (keep) begin
			shadow_bank = ~shadow_bank;
			shadow_len = rx_len > MAXB ? MAXB : rx_len;
			shadow_sum = rx_sum16;
		end
		rx_len = 0;
		rx_sum16 = '0;
		rx_sum8 = '0;
		return kind;
	endfunction

	task automatic predict_holder(input dmxsip_pkg::in_t it);
		int unsigned slot;
		logic [2:0] kind;
		if (it.operation == dmxsip_pkg::OP_RECEIVE) begin
			slot = rx_len;
			// Bytes past the store are neither kept nor summed.
			if (slot < MAXB) begin
				shadow_bytes[(shadow_bank ? 0 : MAXB) + slot] = it.data_byte;
				rx_sum16 = rx_sum16 + it.data_byte;
				if (slot < dmxsip_pkg::SIP_LEN) rx_head[slot] = it.data_byte;
				if (slot < dmxsip_pkg::SIP_LEN - 1) rx_sum8 = rx_sum8 + it.data_byte;
			end
			if (rx_len <= MAXB) rx_len++;
			if (it.last_byte) begin
				kind = close_packet();
				results_due.push_back(shape_result(kind, 8'h00));
			end
		end else if (held || shadow_len == 0 ||
				shadow_bytes[shadow_bank ? MAXB : 0] == shadow_code) begin
			results_due.push_back(shape_result(dmxsip_pkg::KIND_UNAVAIL, 8'h00));
		end else if (it.channel >= shadow_len) begin
			results_due.push_back(shape_result(dmxsip_pkg::KIND_RANGE, 8'h00));
		end else begin
			results_due.push_back(shape_result(dmxsip_pkg::KIND_READ,
				shadow_bytes[(shadow_bank ? MAXB : 0) + it.channel]));
			if (it.release_req) shadow_len = 0;
		end
	endtask

	task automatic check_result(input dmxsip_pkg::out_t got);
		dmxsip_pkg::out_t want;
		kinds_seen[got.result_kind]++;
		if (results_due.size() == 0) begin
			$error("result transaction with none expected, result_kind %0d", got.result_kind);
			fail_count++;
		end else begin
			want = results_due.pop_front();
			if (got.result_kind !== want.result_kind) begin
				$error("result_kind: expected %0d, got %0d", want.result_kind, got.result_kind);
				fail_count++;
			end
			if (got.read_data !== want.read_data) begin
				$error("read_data: expected %0h, got %0h", want.read_data, got.read_data);
				fail_count++;
			end
			if (got.sip_sequence !== want.sip_sequence) begin
				$error("sip_sequence: expected %0h, got %0h", want.sip_sequence,
					got.sip_sequence);
				fail_count++;
			end
			if (got.sip_universe !== want.sip_universe) begin
				$error("sip_universe: expected %0h, got %0h", want.sip_universe,
					got.sip_universe);
				fail_count++;
			end
			if (got.sip_level !== want.sip_level) begin
				$error("sip_level: expected %0h, got %0h", want.sip_level, got.sip_level);
				fail_count++;
			end
			if (got.sip_version !== want.sip_version) begin
				$error("sip_version: expected %0h, got %0h", want.sip_version, got.sip_version);
				fail_count++;
			end
			if (got.sip_packet_length !== want.sip_packet_length) begin
				$error("sip_packet_length: expected %0h, got %0h", want.sip_packet_length,
					got.sip_packet_length);
				fail_count++;
			end
			if (got.sip_packet_count !== want.sip_packet_count) begin
				$error("sip_packet_count: expected %0h, got %0h", want.sip_packet_count,
					got.sip_packet_count);
				fail_count++;
			end
			if (got.previous_checksum_ok !== want.previous_checksum_ok) begin
				$error("previous_checksum_ok: expected %0b, got %0b",
					want.previous_checksum_ok, got.previous_checksum_ok);
				fail_count++;
			end
			if (got.previous_present !== want.previous_present) begin
				$error("previous_present: expected %0b, got %0b", want.previous_present,
					got.previous_present);
				fail_count++;
			end
		end
	endtask

	// Mostly short pauses, a few long ones, and now and then a calm stretch with none.
	function automatic int unsigned draw_pause(inout int unsigned calm);
		int unsigned r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 2) calm = $urandom_range(30, 150);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			item <= '0;
			send_gap <= 0;
		end else if (!item_valid || item_ready) begin
			if (item_valid) begin
				predict_holder(item);
				if (item.operation == dmxsip_pkg::OP_RECEIVE) n_bytes++;
				else n_reads++;
			end
			if (send_gap == 0 && items_to_send.size() > 0) begin
				item <= items_to_send.pop_front();
				item_valid <= 1'b1;
				send_gap <= draw_pause(send_calm);
			end else begin
				item_valid <= 1'b0;
				if (send_gap > 0) send_gap <= send_gap - 1;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
			stall_left <= 0;
		end else begin
			if (result_valid && result_ready) check_result(result);
			if (stall_left > 0) begin
				result_ready <= 1'b0;
				stall_left <= stall_left - 1;
			end else begin
				result_ready <= 1'b1;
				stall_left <= draw_pause(stall_calm);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && !(item_valid && item_ready) && !(result_valid && result_ready) &&
				!(cfg_valid && cfg_ready)) begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end
		end else begin
			idle_cycles <= 0;
		end
	end

	task automatic queue_byte(input logic [7:0] b, input logic last);
		dmxsip_pkg::in_t it;
		it.operation = dmxsip_pkg::OP_RECEIVE;
		it.data_byte = b;
		it.last_byte = last;
		it.channel = 10'($urandom_range(0, 1023));
		it.release_req = 1'($urandom_range(0, 1));
		items_to_send.push_back(it);
		gen_count++;
	endtask

	task automatic queue_read(input logic [9:0] ch, input logic rel);
		dmxsip_pkg::in_t it;
		it.operation = dmxsip_pkg::OP_READ;
		it.data_byte = 8'($urandom_range(0, 255));
		it.last_byte = 1'($urandom_range(0, 1));
		it.channel = ch;
		it.release_req = rel;
		items_to_send.push_back(it);
		gen_count++;
	endtask

	function automatic logic [9:0] pick_channel();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 70) return 10'($urandom_range(0, gen_last_len));
		if (r < 90) return 10'($urandom_range(0, 40));
		return 10'($urandom_range(0, 1023));
	endfunction

	function automatic int unsigned pick_len();
		if ($urandom_range(0, 9) < 8) return $urandom_range(1, 40);
		return $urandom_range(41, 120);
	endfunction

	function automatic logic [7:0] other_code();
		logic [7:0] c;
		do c = 8'($urandom_range(1, 255)); while (c == gen_code);
		return c;
	endfunction

	function automatic sip_flaw_t pick_flaw();
		case ($urandom_range(0, 2))
			0: return FLAW_SUM;
			1: return FLAW_SHORT;
			default: return FLAW_LONG;
		endcase
	endfunction

	task automatic queue_read_burst(input int unsigned n);
		for (int unsigned i = 0; i < n; i++)
			queue_read(pick_channel(), $urandom_range(0, 7) == 0);
	endtask

	task automatic send_packet(input logic [7:0] start, input int unsigned len);
		logic [7:0] b;
		logic [15:0] sum;
		sum = '0;
		for (int unsigned i = 0; i < len; i++) begin
			b = (i == 0) ? start : 8'($urandom_range(0, 255));
			if (i < MAXB) sum = sum + b;
			queue_byte(b, i == len - 1);
			// Reads may slip in between the bytes of a packet.
			if (i != len - 1 && $urandom_range(0, 15) == 0)
				queue_read(pick_channel(), $urandom_range(0, 3) == 0);
		end
		gen_last_sum = sum;
		gen_last_len = len > MAXB ? MAXB : len;
	endtask

	task automatic send_sip(input logic hold, input logic good, input sip_flaw_t flaw);
		logic [7:0] body [0:dmxsip_pkg::SIP_LEN-1];
		logic [7:0] sum8;
		logic [15:0] word;
		logic [15:0] sum;
		int unsigned len;
		if (good) word = ~gen_last_sum;
		else word = 16'($urandom_range(0, 65535));
		body[0] = gen_code;
		body[1] = 8'(dmxsip_pkg::SIP_LEN);
		body[2] = {7'($urandom_range(0, 127)), hold};
		body[3] = word[15:8];
		body[4] = word[7:0];
		for (int i = 5; i < dmxsip_pkg::SIP_LEN - 1; i++) body[i] = 8'($urandom_range(0, 255));
		sum8 = '0;
		for (int i = 0; i < dmxsip_pkg::SIP_LEN - 1; i++) sum8 = sum8 + body[i];
		body[dmxsip_pkg::SIP_LEN-1] = ~sum8;
		len = dmxsip_pkg::SIP_LEN;
		case (flaw)
			FLAW_SUM: body[dmxsip_pkg::SIP_LEN-1] = body[dmxsip_pkg::SIP_LEN-1] ^
				8'($urandom_range(1, 255));
			FLAW_SHORT: len = $urandom_range(1, dmxsip_pkg::SIP_LEN - 1);
			FLAW_LONG: len = $urandom_range(dmxsip_pkg::SIP_LEN + 1, 40);
			default: len = dmxsip_pkg::SIP_LEN;
		endcase
		sum = '0;
		for (int unsigned i = 0; i < len; i++) begin
			if (i < dmxsip_pkg::SIP_LEN) begin
				sum = sum + body[i];
				queue_byte(body[i], i == len - 1);
			end else begin
				body[0] = 8'($urandom_range(0, 255));
				sum = sum + body[0];
				queue_byte(body[0], i == len - 1);
			end
		end
		gen_last_sum = sum;
		gen_last_len = len;
	endtask

	// Arm the hold, send the packet to be held, then let the next packet settle it.
	task automatic hold_sequence();
		int unsigned r;
		send_sip(1'b1, 1'b1, FLAW_NONE);
		if ($urandom_range(0, 3) == 0) send_sip(1'($urandom_range(0, 1)), 1'b1, FLAW_NONE);
		send_packet(dmxsip_pkg::NULL_START_CODE, pick_len());
		queue_read_burst($urandom_range(1, 2));
		r = $urandom_range(0, 99);
		if (r < 70) send_sip($urandom_range(0, 3) == 0, $urandom_range(0, 4) != 0, FLAW_NONE);
		else if (r < 80) send_sip(1'b0, 1'b1, pick_flaw());
		else if (r < 90) send_packet(dmxsip_pkg::NULL_START_CODE, pick_len());
		else send_packet(other_code(), pick_len());
		queue_read_burst($urandom_range(1, 3));
	endtask

	task automatic send_long_packet(input int unsigned len);
		send_packet(dmxsip_pkg::NULL_START_CODE, len);
		queue_read(10'(MAXB - 2), 1'b0);
		queue_read(10'(MAXB - 1), 1'b0);
		queue_read(10'(MAXB), 1'b0);
		send_sip(1'b0, 1'b1, FLAW_NONE);
	endtask

	task automatic drain_block();
		while (items_to_send.size() != 0 || item_valid || results_due.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic set_start_code(input logic [7:0] code);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= code;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		shadow_code = code;
		gen_code = code;
		code_settings++;
		cfg_valid <= 1'b0;
	endtask

	task automatic random_phase(input int unsigned target, input int unsigned longs);
		int unsigned r;
		gen_count = 0;
		while (gen_count < target || longs > 0) begin
			r = $urandom_range(0, 99);
			if (longs > 0 && (r == 0 || gen_count >= target)) begin
				send_long_packet(MAXB + $urandom_range(1, 8));
				longs--;
			end else if (r < 25) begin
				hold_sequence();
			end else if (r < 42) begin
				send_packet(dmxsip_pkg::NULL_START_CODE, pick_len());
				queue_read_burst($urandom_range(1, 4));
			end else if (r < 55) begin
				send_sip($urandom_range(0, 3) == 0, $urandom_range(0, 3) != 0, FLAW_NONE);
			end else if (r < 65) begin
				send_sip(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), pick_flaw());
			end else if (r < 75) begin
				send_packet(other_code(), pick_len());
				queue_read_burst($urandom_range(0, 2));
			end else if (r < 90) begin
				queue_read_burst($urandom_range(1, 3));
			end else begin
				send_packet(8'($urandom_range(0, 255)), $urandom_range(1, 30));
			end
		end
		drain_block();
	endtask

	initial begin
		for (int i = 0; i < dmxsip_pkg::SIP_LEN; i++) rx_head[i] = 8'h00;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Empty store, extreme bytes and channels, release, a one-byte SIP.
		queue_read(10'd0, 1'b1);
		queue_byte(dmxsip_pkg::NULL_START_CODE, 1'b0);
		queue_byte(8'hFF, 1'b0);
		queue_byte(8'h00, 1'b1);
		queue_read(10'd2, 1'b0);
		queue_read(10'd3, 1'b0);
		queue_read(10'd1023, 1'b0);
		queue_read(10'd1, 1'b1);
		queue_read(10'd0, 1'b0);
		queue_byte(gen_code, 1'b1);
		queue_read(10'd0, 1'b0);
		queue_byte(8'h80, 1'b0);
		queue_byte(8'h7F, 1'b1);
		queue_read(10'd0, 1'b0);
		queue_read(10'd512, 1'b0);
		queue_read(10'd1, 1'b1);
		gen_last_sum = 16'h00FF;
		gen_last_len = 2;

		random_phase(20, 1);
		set_start_code(8'h00);
		random_phase(5, 0);
		set_start_code(8'hFF);
		random_phase(5, 0);
		set_start_code(8'($urandom_range(1, 254)));
		random_phase(5, 0);
		set_start_code(dmxsip_pkg::START_CODE_RESET);
		random_phase(5, 0);

		if (results_due.size() != 0) begin
			$error("%0d expected results never arrived", results_due.size());
			fail_count++;
		end
		$display("Drove %0d packet bytes and %0d channel reads under %0d start code values.",
			n_bytes, n_reads, code_settings);
		$display("Results: %0d stored, %0d SIP ok, %0d SIP bad, %0d read, %0d unavail, %0d range.",
			kinds_seen[dmxsip_pkg::KIND_STORED], kinds_seen[dmxsip_pkg::KIND_SIP_OK],
			kinds_seen[dmxsip_pkg::KIND_SIP_BAD], kinds_seen[dmxsip_pkg::KIND_READ],
			kinds_seen[dmxsip_pkg::KIND_UNAVAIL], kinds_seen[dmxsip_pkg::KIND_RANGE]);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// File: sim.f
sv/dmxsip_pkg.sv
sv/dmxsip_store.sv
sv/dmx_sip_packet_holder_core.sv
sv/dmxsip_checker.sv
tb/testbench.sv
